### rtl/mono_note_oscillator_macros.svh
// assertion helpers shared by the oscillator rtl
`ifndef MONO_NOTE_OSCILLATOR_MACROS_SVH
`define MONO_NOTE_OSCILLATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MNO_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MNO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mno_pkg.sv
package mno_pkg;

    // build defaults
    localparam int unsigned TICK_RATE_DEF       = 48000;
    localparam int unsigned SINE_TABLE_BITS_DEF = 10;

    // command codes of an input word
    typedef enum logic [1:0] {
        CMD_TICK        = 2'd0,
        CMD_NOTE_ON     = 2'd1,
        CMD_NOTE_OFF    = 2'd2,
        CMD_VOICE_RESET = 2'd3
    } command_t;

    // waveform register codes
    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SINE     = 2'd2,
        WAVE_SILENT   = 2'd3
    } wave_t;

    // 2^(s/12) in q30, one entry per semitone
    localparam logic [63:0] SEMI [12] = '{
        64'd1073741824, 64'd1137589835, 64'd1205234447, 64'd1276901417,
        64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
        64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
    };

    // sin(pi/2 * t) series coefficients in q30, magnitudes
    localparam logic [63:0] SC1 = 64'd1686629713;
    localparam logic [63:0] SC3 = 64'd693598669;
    localparam logic [63:0] SC5 = 64'd85569306;
    localparam logic [63:0] SC7 = 64'd5026995;
    localparam logic [63:0] SC9 = 64'd172272;

    localparam logic [63:0] Q15_HALF = 64'd16384;
    localparam logic [63:0] Q15_MAX  = 64'd32767;

    // quarter-wave sine magnitude in q15 for a q30 angle within the quadrant
    function automatic logic [14:0] sine_mag(input logic [63:0] x);
        logic [63:0] t2;
        logic [63:0] a;
        logic [63:0] s;
        t2 = (x * x) >> 30;
        a  = SC7 - ((t2 * SC9) >> 30);
        a  = SC5 - ((t2 * a) >> 30);
        a  = SC3 - ((t2 * a) >> 30);
        a  = SC1 - ((t2 * a) >> 30);
        s  = (x * a) >> 30;
        s  = (s + Q15_HALF) >> 15;
        if (s > Q15_MAX)
        begin
            s = Q15_MAX;
        end
        return s[14:0];
    endfunction

endpackage

### rtl/mno_wave.sv
module mno_wave #(
    parameter int unsigned SINE_TABLE_BITS = mno_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        phase,
    input  logic [31:0]        phase_next,
    input  mno_pkg::wave_t     wave,
    output logic signed [15:0] sample
);
    import mno_pkg::*;

    localparam int unsigned QBITS  = SINE_TABLE_BITS - 2;
    localparam int unsigned QDEPTH = (1 << QBITS) + 1;
    localparam logic [QBITS:0] QFULL = (QBITS + 1)'(1) << QBITS;

    // quarter-wave rom, end point included for the falling quadrants
    logic [14:0] sine_rom [QDEPTH];

    for (genvar k = 0; k < QDEPTH; k++)
    begin : g_rom
        assign sine_rom[k] = sine_mag(64'(k) << (30 - QBITS));
    end

    // fold the coming phase into the quarter wave
    logic [QBITS-1:0] frac_next;
    logic [QBITS:0]   rom_addr;

    assign frac_next = phase_next[29 -: QBITS];
    assign rom_addr  = phase_next[30] ? (QFULL - {1'b0, frac_next}) : {1'b0, frac_next};

    // registered rom read keeps the magnitude aligned with the phase register
    logic [14:0] sine_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sine_mag_reg <= '0;
        end
        else
        begin
            sine_mag_reg <= sine_rom[rom_addr];
        end
    end

    // triangle from the top half of the phase
    logic signed [17:0] tri_dev;
    logic signed [17:0] tri_val;
    logic signed [15:0] tri_sample;

    always_comb
    begin
        if (phase[31])
        begin
            tri_dev = $signed({2'b00, phase[31:16]}) - 18'sd32768;
        end
        else
        begin
            tri_dev = 18'sd32768 - $signed({2'b00, phase[31:16]});
        end
        tri_val = 18'sd32768 - (tri_dev <<< 1);
        if (tri_val > 18'sd32767)
        begin
            tri_sample = 16'sd32767;
        end
        else
        begin
            tri_sample = tri_val[15:0];
        end
    end

    // sine sign from the upper half turn
    logic signed [15:0] sine_sample;

    assign sine_sample = phase[31] ? 16'(-$signed({1'b0, sine_mag_reg}))
                                   : $signed({1'b0, sine_mag_reg});

    // waveform select
    always_comb
    begin
        unique case (wave)
            WAVE_SQUARE:   sample = phase[31] ? -16'sd32768 : 16'sd32767;
            WAVE_TRIANGLE: sample = tri_sample;
            WAVE_SINE:     sample = sine_sample;
            WAVE_SILENT:   sample = '0;
        endcase
    end

endmodule

### rtl/mono_note_oscillator.sv
// output: sample_valid rises once a tick word has gone from the input register
// into the sample register; a held sample that is not taken stalls the tick there
// throughput: one word per cycle unless a tick waits on a held sample; one pass of
// phase add, increment table lookup and waveform shaping, input to sample register
// reset: rst_n is asynchronous, active low; phase, voice on flag, note and waveform
// clear at once, no clearing pass, words are taken in the first cycle after reset
`include "mono_note_oscillator_macros.svh"

module mono_note_oscillator #(
    parameter int unsigned TICK_RATE       = mno_pkg::TICK_RATE_DEF,
    parameter int unsigned SINE_TABLE_BITS = mno_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         command,
    input  logic [6:0]         midi_note,
    output logic               sample_valid,
    input  logic               sample_ready,
    output logic signed [15:0] sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         waveform
);
    import mno_pkg::*;

    localparam logic [63:0] DEN = 64'(16 * TICK_RATE);

    // per-note phase increment, equal temperament from a4 at note 69
    function automatic logic [31:0] note_inc(input int unsigned note);
        int unsigned d;
        int unsigned oct;
        int unsigned s;
        logic [63:0] num;
        logic [63:0] quo;
        d   = note + 3;
        oct = d / 12;
        s   = d % 12;
        num = (64'd440 * SEMI[s]) << oct;
        quo = (num + DEN / 2) / DEN;
        return quo[31:0];
    endfunction

    logic [31:0] inc_tab [128];

    for (genvar n = 0; n < 128; n++)
    begin : g_inc
        localparam logic [31:0] INC = note_inc(n);
        assign inc_tab[n] = INC;
    end

    // configuration register
    wave_t waveform_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= WAVE_SQUARE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            waveform_reg <= wave_t'(waveform);
        end
    end

    // input register and flow control
    logic     s1_valid_reg;
    command_t cmd_reg;
    logic [6:0] note_reg;
    logic     out_valid_reg;
    logic     s1_tick;
    logic     s2_free;
    logic     s1_go;

    assign s1_tick    = (cmd_reg == CMD_TICK);
    assign s2_free    = !out_valid_reg || sample_ready;
    assign s1_go      = s1_valid_reg && (!s1_tick || s2_free);
    assign item_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            cmd_reg  <= command_t'(command);
            note_reg <= midi_note;
        end
    end

    // voice state
    logic [31:0] phase_reg;
    logic [31:0] phase_next;
    logic        active_reg;
    logic        active_next;
    logic [6:0]  current_note_reg;
    logic [6:0]  current_note_next;

    always_comb
    begin
        phase_next        = phase_reg;
        active_next       = active_reg;
        current_note_next = current_note_reg;
        if (s1_go)
        begin
            unique case (cmd_reg)
                CMD_TICK:
                begin
                    if (active_reg)
                    begin
                        phase_next = phase_reg + inc_tab[current_note_reg];
                    end
                end
                CMD_NOTE_ON:
                begin
                    current_note_next = note_reg;
                    active_next       = 1'b1;
                end
                CMD_NOTE_OFF:
                begin
                    if (active_reg && (current_note_reg == note_reg))
                    begin
                        active_next = 1'b0;
                    end
                end
                CMD_VOICE_RESET:
                begin
                    phase_next  = '0;
                    active_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= '0;
            active_reg       <= 1'b0;
            current_note_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            active_reg       <= active_next;
            current_note_reg <= current_note_next;
        end
    end

    // waveform shaping of the current phase
    logic signed [15:0] shape_sample;

    mno_wave #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_wave (
        .clk        (clk),
        .rst_n      (rst_n),
        .phase      (phase_reg),
        .phase_next (phase_next),
        .wave       (waveform_reg),
        .sample     (shape_sample)
    );

    // sample register
    logic signed [15:0] sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_tick)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (sample_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_tick)
        begin
            sample_reg <= active_reg ? shape_sample : 16'sd0;
        end
    end

    assign sample_valid = out_valid_reg;
    assign sample       = sample_reg;

    // checks
    `MNO_ASSERT_IMPL(a_tick_has_room, s1_go && s1_tick, s2_free, "tick issued over a held sample")
    `MNO_ASSERT_NEXT(a_voice_reset, s1_go && cmd_reg == CMD_VOICE_RESET, phase_reg == '0 && !active_reg, "voice reset left state")
    `MNO_ASSERT_NEXT(a_idle_tick, s1_go && s1_tick && !active_reg, out_valid_reg && sample_reg == '0 && $stable(phase_reg), "idle tick not silent or phase moved")
    `MNO_ASSERT_NEXT(a_note_on, s1_go && cmd_reg == CMD_NOTE_ON, active_reg && current_note_reg == $past(note_reg), "note on not taken")
    `MNO_ASSERT_NEXT(a_stall_hold, s1_valid_reg && !s1_go, s1_valid_reg && $stable(cmd_reg) && $stable(note_reg), "stalled word lost")

endmodule
